FILE: src/mji_pkg.sv
// Shared widths and constants for the minimum-jerk interpolator.
package mji_pkg;

  localparam int POS_W   = 32;  // Q16.16 position
  localparam int DELTA_W = 33;  // end minus start, signed
  localparam int SPAN_W  = 7;   // span field
  localparam int IDX_W   = 6;   // step_index field

  localparam int DEFAULT_MAX_SPAN = 64;

  // Blend arithmetic, sized for the widest span the 7-bit field can carry.
  localparam int N2_W   = 2 * SPAN_W;       // n*n, i*i, i*n
  localparam int N4_W   = 4 * SPAN_W;       // n^4
  localparam int DEN_W  = 5 * SPAN_W;       // n^5, and the numerator
  localparam int I3_W   = 3 * SPAN_W;       // i^3
  localparam int Q_W    = 18;               // 10n^2 - 15in + 6i^2
  localparam int QX_W   = Q_W + 2;          // headroom while forming q
  localparam int REM_W  = DEN_W + 1;        // divider remainder
  localparam int QUO_W  = 32;               // one integer bit and 31 fraction bits
  localparam int BLEND_W = 31;              // unsigned Q1.30, at most 1.0
  localparam int BLO_W  = 16;               // low slice of the blend
  localparam int BHI_W  = BLEND_W - BLO_W;  // high slice of the blend
  localparam int DIV_STEPS = QUO_W;
  localparam int DCNT_W = $clog2(DIV_STEPS);

  // Shared multiplier: signed operand A times unsigned operand B.
  localparam int MUL_A_W = DELTA_W + 1;
  localparam int MUL_B_W = I3_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
  localparam int ACC_W   = 64;
  localparam int FRAC_W  = 30;

  localparam logic [QUO_W-1:0] QUO_MAX = 32'h8000_0000;

endpackage

FILE: src/min_jerk_interpolator_core.sv
// Minimum-jerk quintic interpolator: one shared multiplier and a bit-serial divider.
// Flow: span setup (n^2, n^4, n^5), then for each interior point 10 multiply,
// add and round steps, a 32-step restoring divide, and one handoff to the output.
// Throughput: one input transaction at a time; in_ready is high only when idle.
// The divider, one quotient bit a cycle, sets the per-point cost.
// Reset (rst, synchronous, active high) returns the sequencer to idle and drops out_valid.
module min_jerk_interpolator_core #(
  parameter int MAX_SPAN = mji_pkg::DEFAULT_MAX_SPAN
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [mji_pkg::POS_W-1:0]  start_position,
  input  logic signed [mji_pkg::POS_W-1:0]  end_position,
  input  logic        [mji_pkg::SPAN_W-1:0] span,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mji_pkg::POS_W-1:0]  position,
  output logic        [mji_pkg::IDX_W-1:0]  step_index,
  output logic                              last
);

  // Sequencer states. The span setup runs once per transaction with a span above
  // one; the point states loop once per interior point.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_N2   = 4'd1;   // n*n
  localparam logic [3:0] S_N4   = 4'd2;   // n^2*n^2
  localparam logic [3:0] S_DEN  = 4'd3;   // n^4*n
  localparam logic [3:0] S_I2   = 4'd4;   // i*i, accumulator preset
  localparam logic [3:0] S_IN   = 4'd5;   // i*n
  localparam logic [3:0] S_I3   = 4'd6;   // i^2*i
  localparam logic [3:0] S_Q    = 4'd7;   // quadratic factor by shift-add
  localparam logic [3:0] S_NUM  = 4'd8;   // q*i^3
  localparam logic [3:0] S_DIV  = 4'd9;   // numerator / n^5, one bit a cycle
  localparam logic [3:0] S_RND  = 4'd10;  // round quotient to Q1.30
  localparam logic [3:0] S_MLO  = 4'd11;  // delta * low blend slice
  localparam logic [3:0] S_ALO  = 4'd12;
  localparam logic [3:0] S_MHI  = 4'd13;  // delta * high blend slice
  localparam logic [3:0] S_AHI  = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;  // hand the point to the output register

  logic [3:0] state;
  logic [3:0] state_next;

  // Held span operands.
  logic signed [mji_pkg::POS_W-1:0]   held_start;
  logic signed [mji_pkg::DELTA_W-1:0] held_delta;
  logic [mji_pkg::SPAN_W-1:0]         held_span;
  logic [mji_pkg::SPAN_W-1:0]         step_counter;

  // Per-point working registers.
  logic [mji_pkg::N2_W-1:0]    n2;
  logic [mji_pkg::N4_W-1:0]    n4;
  logic [mji_pkg::DEN_W-1:0]   den;
  logic [mji_pkg::N2_W-1:0]    i2;
  logic [mji_pkg::N2_W-1:0]    i_n;
  logic [mji_pkg::I3_W-1:0]    i3;
  logic [mji_pkg::Q_W-1:0]     q;
  logic [mji_pkg::REM_W-1:0]   rem;
  logic [mji_pkg::QUO_W-1:0]   quo;
  logic [mji_pkg::DCNT_W-1:0]  div_cnt;
  logic [mji_pkg::BLEND_W-1:0] blend;
  logic signed [mji_pkg::PROD_W-1:0] prod;
  logic signed [mji_pkg::ACC_W-1:0]  acc;

  logic [mji_pkg::SPAN_W-1:0] span_eff;
  logic                        is_last;
  logic                        out_free;
  logic                        accept;

  // Shared multiplier.
  logic signed [mji_pkg::MUL_A_W-1:0] mul_a;
  logic        [mji_pkg::MUL_B_W-1:0] mul_b;
  logic signed [mji_pkg::PROD_W-1:0]  mul_p;

  // Quadratic factor, divider step and saturation.
  logic [mji_pkg::QX_W-1:0]    n2_x;
  logic [mji_pkg::QX_W-1:0]    i2_x;
  logic [mji_pkg::QX_W-1:0]    in_x;
  logic [mji_pkg::QX_W-1:0]    q_calc;
  logic [mji_pkg::REM_W:0]     div_diff;
  logic                        div_ge;
  logic [mji_pkg::REM_W-1:0]   rem_kept;
  logic [mji_pkg::QUO_W:0]     quo_rnd;
  logic signed [mji_pkg::POS_W-1:0] pos_sat;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign is_last  = ((step_counter + 1'b1) == held_span);

  // Spans beyond the configured maximum are clamped to it.
  always_comb begin
    if (int'(span) > MAX_SPAN) begin
      span_eff = mji_pkg::SPAN_W'(MAX_SPAN);
    end else begin
      span_eff = span;
    end
  end

  // Operand selection for the one multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_N2: begin
        mul_a = mji_pkg::MUL_A_W'(held_span);
        mul_b = mji_pkg::MUL_B_W'(held_span);
      end
      S_N4: begin
        mul_a = mji_pkg::MUL_A_W'(n2);
        mul_b = mji_pkg::MUL_B_W'(n2);
      end
      S_DEN: begin
        mul_a = mji_pkg::MUL_A_W'(n4);
        mul_b = mji_pkg::MUL_B_W'(held_span);
      end
      S_I2: begin
        mul_a = mji_pkg::MUL_A_W'(step_counter);
        mul_b = mji_pkg::MUL_B_W'(step_counter);
      end
      S_IN: begin
        mul_a = mji_pkg::MUL_A_W'(step_counter);
        mul_b = mji_pkg::MUL_B_W'(held_span);
      end
      S_I3: begin
        mul_a = mji_pkg::MUL_A_W'(i2);
        mul_b = mji_pkg::MUL_B_W'(step_counter);
      end
      S_NUM: begin
        mul_a = mji_pkg::MUL_A_W'(q);
        mul_b = mji_pkg::MUL_B_W'(i3);
      end
      S_MLO: begin
        mul_a = {held_delta[mji_pkg::DELTA_W-1], held_delta};
        mul_b = mji_pkg::MUL_B_W'(blend[mji_pkg::BLO_W-1:0]);
      end
      S_MHI: begin
        mul_a = {held_delta[mji_pkg::DELTA_W-1], held_delta};
        mul_b = mji_pkg::MUL_B_W'(blend[mji_pkg::BLEND_W-1:mji_pkg::BLO_W]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  // q = 10n^2 + 6i^2 - 15in; the quadratic has no real root, so q stays positive.
  assign n2_x   = mji_pkg::QX_W'(n2);
  assign i2_x   = mji_pkg::QX_W'(i2);
  assign in_x   = mji_pkg::QX_W'(i_n);
  assign q_calc = (n2_x << 3) + (n2_x << 1) + (i2_x << 2) + (i2_x << 1)
                  - ((in_x << 4) - in_x);

  // Restoring divide: the kept remainder always stays below the denominator.
  assign div_diff = {1'b0, rem} - {2'b0, den};
  assign div_ge   = !div_diff[mji_pkg::REM_W];
  assign rem_kept = div_ge ? div_diff[mji_pkg::REM_W-1:0] : rem;

  // Quotient carries one extra fraction bit; add one half and drop it.
  assign quo_rnd = {1'b0, quo} + 1'b1;

  // Saturate the Q16.16 result taken from the top of the accumulator.
  always_comb begin
    if (acc[mji_pkg::ACC_W-1:mji_pkg::ACC_W-3] == 3'b000 ||
        acc[mji_pkg::ACC_W-1:mji_pkg::ACC_W-3] == 3'b111) begin
      pos_sat = acc[mji_pkg::FRAC_W+mji_pkg::POS_W-1:mji_pkg::FRAC_W];
    end else if (acc[mji_pkg::ACC_W-1]) begin
      pos_sat = {1'b1, {(mji_pkg::POS_W-1){1'b0}}};
    end else begin
      pos_sat = {1'b0, {(mji_pkg::POS_W-1){1'b1}}};
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (span_eff > mji_pkg::SPAN_W'(1)) ? S_N2 : S_IDLE;
        end
      end
      S_N2:  state_next = S_N4;
      S_N4:  state_next = S_DEN;
      S_DEN: state_next = S_I2;
      S_I2:  state_next = S_IN;
      S_IN:  state_next = S_I3;
      S_I3:  state_next = S_Q;
      S_Q:   state_next = S_NUM;
      S_NUM: state_next = S_DIV;
      S_DIV: begin
        if (div_cnt == mji_pkg::DCNT_W'(mji_pkg::DIV_STEPS - 1)) begin
          state_next = S_RND;
        end
      end
      S_RND: state_next = S_MLO;
      S_MLO: state_next = S_ALO;
      S_ALO: state_next = S_MHI;
      S_MHI: state_next = S_AHI;
      S_AHI: state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = is_last ? S_IDLE : S_I2;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end else begin
        div_cnt <= '0;
      end
    end
  end

  // Held operands and the step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_start   <= '0;
      held_delta   <= '0;
      held_span    <= '0;
      step_counter <= '0;
    end else begin
      if (accept) begin
        held_start   <= start_position;
        held_delta   <= mji_pkg::DELTA_W'(end_position) - mji_pkg::DELTA_W'(start_position);
        held_span    <= span_eff;
        step_counter <= mji_pkg::SPAN_W'(1);
      end else if (state == S_OUT && out_free && !is_last) begin
        step_counter <= step_counter + 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_N2:  n2  <= mul_p[mji_pkg::N2_W-1:0];
      S_N4:  n4  <= mul_p[mji_pkg::N4_W-1:0];
      S_DEN: den <= mul_p[mji_pkg::DEN_W-1:0];
      S_I2: begin
        i2  <= mul_p[mji_pkg::N2_W-1:0];
        // Start position in Q1.30 scale plus one half for round-to-nearest.
        acc <= {{2{held_start[mji_pkg::POS_W-1]}}, held_start, 1'b1,
                {(mji_pkg::FRAC_W-1){1'b0}}};
      end
      S_IN:  i_n <= mul_p[mji_pkg::N2_W-1:0];
      S_I3:  i3  <= mul_p[mji_pkg::I3_W-1:0];
      S_Q:   q   <= q_calc[mji_pkg::Q_W-1:0];
      S_NUM: begin
        rem <= {1'b0, mul_p[mji_pkg::DEN_W-1:0]};
        quo <= '0;
      end
      S_DIV: begin
        quo <= {quo[mji_pkg::QUO_W-2:0], div_ge};
        rem <= {rem_kept[mji_pkg::REM_W-2:0], 1'b0};
      end
      S_RND: blend <= quo_rnd[mji_pkg::BLEND_W:1];
      S_MLO: prod  <= mul_p;
      S_ALO: acc   <= acc + mji_pkg::ACC_W'(prod);
      S_MHI: prod  <= mul_p;
      S_AHI: acc   <= acc + {prod[mji_pkg::ACC_W-mji_pkg::BLO_W-1:0],
                             {mji_pkg::BLO_W{1'b0}}};
      default: begin
      end
    endcase
  end

  // Output register: loaded only when it is empty or its point is being taken.
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      position   <= pos_sat;
      step_index <= step_counter[mji_pkg::IDX_W-1:0];
      last       <= is_last;
    end
  end

  // Once an item is taken the block stays busy for at least the setup.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept && span_eff > mji_pkg::SPAN_W'(1) |=> !in_ready)
    else $error("in_ready high right after accepting a multi-point span");

  // The blend never exceeds one, so the doubled quotient stays at or below 2^31.
  a_blend_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_RND |-> quo <= mji_pkg::QUO_MAX)
    else $error("blend quotient above one");

  // A point is never handed over while the output register still holds one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && state == S_OUT |=> state == S_OUT || !out_valid)
    else $error("sequencer left the output state while the result was stalled");

  // Interior points are numbered from one.
  a_index_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> step_counter != '0)
    else $error("interior point with index zero");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the minimum-jerk quintic interpolator core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mji_pkg::*;

  // Interpolation depth used by the instance; spans above it are clamped.
  localparam int unsigned SPAN_LIMIT   = DEFAULT_MAX_SPAN;
  localparam int unsigned MAX_WAIT     = 13;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned HOLD_CYCLES  = 800;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fff_ffff;

  // One interior point of a trajectory segment as the block should emit it.
  typedef struct {
    logic signed [POS_W-1:0] position;
    logic        [IDX_W-1:0] step_index;
    logic                    last;
  } traj_point_t;

  // Holds the points still owed by the block and compares arriving ones in order.
  class traj_scoreboard;
    traj_point_t expected_points[$];
    int unsigned segments;
    int unsigned points_checked;
    int unsigned failures;

    // Blend 10s^3 - 15s^4 + 6s^5 with s = i/n, in unsigned Q1.30, rounded half up.
    function longint unsigned quintic_blend(longint unsigned i, longint unsigned n);
      longint unsigned q, num, den, quo, rem;
      q   = 10 * n * n + 6 * i * i - 15 * i * n;
      num = i * i * i * q;
      den = n * n * n * n * n;
      quo = num / den;
      rem = num % den;
      for (int k = 0; k < 31; k++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= den) begin
          rem = rem - den;
          quo = quo | 64'd1;
        end
      end
      return (quo + 64'd1) >> 1;
    endfunction

    // Works out every interior point of an accepted segment and queues it.
    function void note_segment(logic signed [POS_W-1:0] x0, logic signed [POS_W-1:0] x1,
                               logic [SPAN_W-1:0] span_in);
      longint          delta, total, pos;
      longint unsigned n, b;
      traj_point_t     pt;
      segments++;
      n = (span_in > SPAN_LIMIT) ? SPAN_LIMIT : span_in;
      delta = longint'(x1) - longint'(x0);
      for (longint unsigned i = 1; i < n; i++) begin
        b = quintic_blend(i, n);
        total = longint'(x0) * (64'sd1 <<< FRAC_W) + delta * $signed(b)
                + (64'sd1 <<< (FRAC_W - 1));
        // Arithmetic shift gives the floor, so this rounds half toward plus infinity.
        pos = total >>> FRAC_W;
        if (pos > longint'(POS_MAX)) pos = longint'(POS_MAX);
        if (pos < longint'(POS_MIN)) pos = longint'(POS_MIN);
        pt.position   = pos[POS_W-1:0];
        pt.step_index = i[IDX_W-1:0];
        pt.last       = (i + 1 == n);
        expected_points.push_back(pt);
      end
    endfunction

    function void check_point(logic signed [POS_W-1:0] pos, logic [IDX_W-1:0] idx,
                              logic lst);
      traj_point_t pt;
      if (expected_points.size() == 0) begin
        $display("%0t: point with no expectation: position %0d step_index %0d last %0b",
                 $time, pos, idx, lst);
        failures++;
        return;
      end
      pt = expected_points.pop_front();
      points_checked++;
      if (pos !== pt.position) begin
        $display("%0t: position expected %0d got %0d (step %0d)",
                 $time, pt.position, pos, pt.step_index);
        failures++;
      end
      if (idx !== pt.step_index) begin
        $display("%0t: step_index expected %0d got %0d", $time, pt.step_index, idx);
        failures++;
      end
      if (lst !== pt.last) begin
        $display("%0t: last expected %0b got %0b (step %0d)",
                 $time, pt.last, lst, pt.step_index);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_points.size();
    endfunction
  endclass

  // All block inputs start at known values; reset is high from time zero.
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [POS_W-1:0] start_position = '0;
  logic signed [POS_W-1:0] end_position = '0;
  logic        [SPAN_W-1:0] span = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [POS_W-1:0] position;
  logic        [IDX_W-1:0] step_index;
  logic                    last;

  // Testbench-only controls: a burst mode with no idling on either side, and a
  // long receiver hold-off that lets the block back up and stall its input.
  logic no_idle  = 1'b0;
  logic hold_off = 1'b0;

  traj_scoreboard sb = new();

  min_jerk_interpolator_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .start_position(start_position),
    .end_position  (end_position),
    .span          (span),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .position      (position),
    .step_index    (step_index),
    .last          (last)
  );

  always #5 clk = ~clk;

  // Offers one segment after a random gap and returns at the falling edge after
  // the transaction. When the gap is zero, valid stays high from the last one.
  task automatic send_segment(input logic signed [POS_W-1:0] x0,
                              input logic signed [POS_W-1:0] x1,
                              input logic [SPAN_W-1:0] steps);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start_position <= x0;
    end_position   <= x1;
    span           <= steps;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_segment(x0, x1, steps);
    @(negedge clk);
  endtask

  // Sender pause: nothing new is offered until every owed point has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Draws one random segment. Most spans are short so the run stays quick, a
  // few reach the full depth, and some exceed it to exercise clamping.
  task automatic send_random_segment();
    logic signed [POS_W-1:0] x0, x1;
    logic        [SPAN_W-1:0] steps;
    int unsigned kind, r;
    x0 = $urandom;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      x1 = $urandom;
    end else if (kind < 7) begin
      x1 = x0 + $signed(POS_W'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000;
    end else if (kind < 9) begin
      case ($urandom_range(0, 4))
        0: x0 = POS_MIN;
        1: x0 = POS_MAX;
        2: x0 = '0;
        3: x0 = -32'sd1;
        default: x0 = 32'sd1;
      endcase
      x1 = ($urandom_range(0, 1) == 0) ? POS_MIN : POS_MAX;
    end else begin
      x1 = x0;
    end
    r = $urandom_range(0, 99);
    if (r < 70)      steps = SPAN_W'($urandom_range(0, 12));
    else if (r < 85) steps = SPAN_W'($urandom_range(13, 40));
    else if (r < 93) steps = SPAN_W'($urandom_range(41, SPAN_LIMIT));
    else             steps = SPAN_W'($urandom_range(SPAN_LIMIT + 1, 127));
    send_segment(x0, x1, steps);
  endtask

  // Receiver: waits a random number of cycles before each point, honors the
  // hold-off, then takes the transaction and hands it to the scoreboard.
  initial begin
    int unsigned stall;
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      while (hold_off) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      sb.check_point(position, step_index, last);
      @(negedge clk);
    end
  end

  // Two long receiver hold-offs, counted here, while the sender keeps offering.
  initial begin
    int unsigned hold_points[2];
    hold_points[0] = 40;
    hold_points[1] = 260;
    while (rst) @(negedge clk);
    foreach (hold_points[k]) begin
      while (sb.segments < hold_points[k]) @(negedge clk);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_off <= 1'b0;
    end
  end

  // Stimulus: a directed set of extremes and special cases, then random segments.
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Spans of zero and one produce no points at all.
    send_segment('0, '0, 7'd0);
    send_segment(32'sh0001_0000, 32'sh0005_0000, 7'd1);
    // The shortest span that yields a point: the midpoint of the blend.
    send_segment('0, 32'sh0001_0000, 7'd2);
    send_segment('0, POS_MIN, 7'd2);
    // Full-range travel in both directions at the deepest span.
    send_segment(POS_MIN, POS_MAX, 7'd64);
    send_segment(POS_MAX, POS_MIN, 7'd64);
    // Spans beyond the limit are clamped to it.
    send_segment(POS_MIN, POS_MAX, 7'd127);
    send_segment(32'sh1234_5678, -32'sh0000_1234, 7'd65);
    send_segment(-32'sh0000_8000, 32'sh7fff_0000, 7'd100);
    // Tiny and zero travel, where rounding dominates.
    send_segment(-32'sd1, 32'sd1, 7'd3);
    send_segment(32'sd5, 32'sd5, 7'd10);
    send_segment(POS_MAX, POS_MAX, 7'd7);
    send_segment(POS_MIN, POS_MIN, 7'd7);
    send_segment('0, POS_MAX, 7'd63);
    send_segment(POS_MAX, '0, 7'd5);
    send_segment(32'sh0000_ffff, 32'shffff_0001, 7'd4);
    send_segment(32'sh5555_5555, 32'shaaaa_aaaa, 7'd33);
    send_segment(32'shaaaa_aaaa, 32'sh5555_5555, 7'd64);
    send_segment(-32'sd1, '0, 7'd127);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Every so often switch between random idling and a burst without gaps.
      if (n % 25 == 0) no_idle <= ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) wait_drained();
      send_random_segment();
    end
    in_valid <= 1'b0;
    no_idle  <= 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d segments and %0d interior points: spans 0 to 127 with clamping,",
             sb.segments, sb.points_checked);
    $display("full-scale and zero travel, two long output stalls and a full input drain.");
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d failures, %0d points still owed", sb.failures, sb.pending());
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #(100_000_000);
    $display("Timeout with %0d points still owed", sb.pending());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
